>>> rtl/array_trie_insert_search_defines.svh
// ----------------------------------------------------------------------------
// Trie assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_TRIE_INSERT_SEARCH_DEFINES_SVH
`define ARRAY_TRIE_INSERT_SEARCH_DEFINES_SVH

// same-cycle implication
`define ATI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trie assertion failed");

// next-cycle implication
`define ATI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trie assertion failed");

`endif

>>> rtl/ati_pkg.sv
// ----------------------------------------------------------------------------
// Trie package
// Default sizes, field widths, command codes and the memory control struct.
// ----------------------------------------------------------------------------
package ati_pkg;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int ALPHABET_DEF   = 26;

    localparam int LETTER_W     = 5;
    localparam int LETTER_CMP_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

endpackage

>>> rtl/ati_cell_ram.sv
// ----------------------------------------------------------------------------
// Trie cell memory
// One entry per (node, letter) edge: end mark and child node. One write and
// one registered read port; a sweep zeroes every entry after reset.
// ----------------------------------------------------------------------------
module ati_cell_ram #(
    parameter int NODE_COUNT = ati_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET   = ati_pkg::ALPHABET_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  ati_pkg::t_ram_ctl                             i_ctl,
    input  logic [$clog2(NODE_COUNT*ALPHABET)-1:0]        i_rd_addr,
    input  logic [$clog2(NODE_COUNT*ALPHABET)-1:0]        i_wr_addr,
    input  logic [$clog2(NODE_COUNT):0]                   i_wr_data,
    output logic [$clog2(NODE_COUNT):0]                   o_rd_data,
    output logic                                          o_clear_busy
);

    localparam int CELLS  = NODE_COUNT * ALPHABET;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DATA_W = $clog2(NODE_COUNT) + 1;

    logic [DATA_W-1:0] r_mem [CELLS];
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              r_clearing;
    logic              n_clearing;

    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clearing <= n_clearing;
        end
    end

    assign w_en   = r_clearing | i_ctl.wr_en;
    assign w_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_data = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clearing;

endmodule

>>> rtl/ati_walk.sv
// ----------------------------------------------------------------------------
// Trie walk controller
// Holds the cursor, the free-node counter and the word flags; reads one edge
// per letter, then allocates, marks or follows it; an insert writes back a new or marked edge.
// ----------------------------------------------------------------------------
module ati_walk #(
    parameter int NODE_COUNT = ati_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET   = ati_pkg::ALPHABET_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_clear_busy,
    input  logic                                          i_start,
    output logic                                          o_busy,
    input  logic                                          i_command,
    input  logic [ati_pkg::LETTER_W-1:0]                  i_letter,
    input  logic                                          i_last_letter,
    output ati_pkg::t_ram_ctl                             o_ctl,
    output logic [$clog2(NODE_COUNT*ALPHABET)-1:0]        o_rd_addr,
    output logic [$clog2(NODE_COUNT*ALPHABET)-1:0]        o_wr_addr,
    output logic [$clog2(NODE_COUNT):0]                   o_wr_data,
    input  logic [$clog2(NODE_COUNT):0]                   i_rd_data,
    output logic                                          o_valid,
    output logic                                          o_found,
    output logic                                          o_table_full
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int CELLS  = NODE_COUNT * ALPHABET;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              r_state,     n_state;
    logic [NODE_W-1:0] r_cursor,    n_cursor;
    logic [FREE_W-1:0] r_next_free, n_next_free;
    logic              r_on_path,   n_on_path;
    logic              r_exhausted, n_exhausted;
    logic              r_cmd,       n_cmd;
    logic              r_last,      n_last;
    logic              r_hit,       n_hit;
    logic [ADDR_W-1:0] r_addr,      n_addr;
    logic              r_valid,     n_valid;
    logic              r_found,     n_found;
    logic              r_full,      n_full;

    logic              take;
    logic              in_range;
    logic              rd_en;
    logic              wr_en;
    logic [NODE_W-1:0] rd_child;
    logic              rd_end;
    logic [NODE_W-1:0] new_child;
    logic              ins_ok;
    logic              srch_found;
    logic              word_full;

    assign o_busy   = i_clear_busy | (r_state == ST_WALK);
    assign take     = i_start & ~o_busy;
    assign in_range = ati_pkg::LETTER_CMP_W'(i_letter) < ati_pkg::LETTER_CMP_W'(ALPHABET);

    assign o_rd_addr = ADDR_W'(r_cursor) * ADDR_W'(ALPHABET) + ADDR_W'(i_letter);
    assign rd_en     = take & r_on_path & in_range;
    assign o_wr_addr = r_addr;
    assign o_ctl     = '{rd_en: rd_en, wr_en: wr_en};

    assign rd_child = i_rd_data[NODE_W-1:0];
    assign rd_end   = i_rd_data[NODE_W];

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_next_free = r_next_free;
        n_on_path   = r_on_path;
        n_exhausted = r_exhausted;
        n_cmd       = r_cmd;
        n_last      = r_last;
        n_hit       = r_hit;
        n_addr      = r_addr;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_full      = r_full;
        new_child   = rd_child;
        ins_ok      = 1'b0;
        srch_found  = 1'b0;
        word_full   = r_exhausted;
        wr_en       = 1'b0;
        o_wr_data   = {rd_end | r_last, rd_child};
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_state = ST_WALK;
                    n_cmd   = i_command;
                    n_last  = i_last_letter;
                    n_hit   = rd_en;
                    n_addr  = o_rd_addr;
                end
            end
            ST_WALK: begin
                n_state = ST_IDLE;
                if (!r_hit) begin
                    n_on_path = 1'b0;
                end else if (r_cmd == ati_pkg::CMD_INSERT) begin
                    ins_ok = 1'b1;
                    if (rd_child == '0) begin
                        if (r_next_free < FREE_W'(NODE_COUNT)) begin
                            new_child   = r_next_free[NODE_W-1:0];
                            n_next_free = r_next_free + FREE_W'(1);
                        end else begin
                            ins_ok      = 1'b0;
                            n_on_path   = 1'b0;
                            n_exhausted = 1'b1;
                            word_full   = 1'b1;
                        end
                    end
                    if (ins_ok) begin
                        wr_en     = (rd_child == '0) | r_last;
                        o_wr_data = {rd_end | r_last, new_child};
                        n_cursor  = new_child;
                    end
                end else begin
                    if (r_last) begin
                        srch_found = rd_end;
                    end else if (rd_child == '0) begin
                        n_on_path = 1'b0;
                    end else begin
                        n_cursor = rd_child;
                    end
                end
                if (r_last) begin
                    n_valid     = 1'b1;
                    n_found     = (r_cmd == ati_pkg::CMD_SEARCH) & srch_found;
                    n_full      = (r_cmd == ati_pkg::CMD_INSERT) & word_full;
                    n_cursor    = '0;
                    n_on_path   = 1'b1;
                    n_exhausted = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_next_free <= FREE_W'(1);
            r_on_path   <= 1'b1;
            r_exhausted <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_next_free <= n_next_free;
            r_on_path   <= n_on_path;
            r_exhausted <= n_exhausted;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_last  <= n_last;
        r_hit   <= n_hit;
        r_addr  <= n_addr;
        r_found <= n_found;
        r_full  <= n_full;
    end

    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_table_full = r_full;

endmodule

>>> rtl/array_trie_insert_search.sv
// ----------------------------------------------------------------------------
// Array trie insert and search
// Letter-serial trie over ALPHABET letters with NODE_COUNT nodes.
//
// Input: a letter transfer happens at a clock edge with start high and busy
// low; i_command (0 insert, 1 search), i_letter and i_last_letter go with it.
// A word is a run of letters closed by one with i_last_letter set.
// Output: the final letter of a word yields one result, o_found and
// o_table_full, shown for exactly one cycle with o_valid high. The receiver
// cannot stall; other letters give no result.
// Timing: each letter is an edge read, then an update and any write back of
// the cell memory; busy stays high for the cycle after a transfer. The
// result strobe is registered from the walk step of the final letter.
// Reset: the walk returns to the root and the free-node counter to 1; then
// a clearing pass zeroes all NODE_COUNT*ALPHABET cells of the cell memory
// (26624 by default), with busy held high.
// A full pool sets o_table_full for an insert and drops the rest of the word.
// ----------------------------------------------------------------------------
`include "array_trie_insert_search_defines.svh"

module array_trie_insert_search #(
    parameter int NODE_COUNT = ati_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET   = ati_pkg::ALPHABET_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_command,
    input  logic [ati_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_last_letter,
    output logic                         o_valid,
    output logic                         o_found,
    output logic                         o_table_full
);

    localparam int CELLS  = NODE_COUNT * ALPHABET;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DATA_W = $clog2(NODE_COUNT) + 1;

    ati_pkg::t_ram_ctl ctl;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;
    logic              clear_busy;

    ati_cell_ram #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET)
    ) u_ram (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .o_rd_data    (rd_data),
        .o_clear_busy (clear_busy)
    );

    ati_walk #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear_busy  (clear_busy),
        .i_start       (start),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .o_ctl         (ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_rd_data     (rd_data),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_table_full  (o_table_full)
    );

    `ATI_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)
    `ATI_ASSERT_IMP(a_valid_after_walk, o_valid, $past(busy))
    `ATI_ASSERT_IMP(a_no_access_clear, clear_busy, !ctl.rd_en && !ctl.wr_en)
    `ATI_ASSERT_IMP(a_found_full_excl, o_valid, !(o_found && o_table_full))

endmodule
